// ===== src/ie_ls_pkg.sv =====
// Package for the information-element list search block.
// Holds the phase type, register indexes, mode codes and descriptor masks.
// No dependencies.
package ie_ls_pkg;

  // Field widths
  localparam int unsigned ByteW = 8;
  localparam int unsigned PosW  = 16;
  localparam int unsigned LenW  = 11;
  localparam int unsigned ModeW = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegMode        = 2'd0;
  localparam logic [CfgIdxW-1:0] RegTargetId    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegTargetLong  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegTargetSubId = 2'd3;

  // Descriptor layouts
  localparam logic [ModeW-1:0] ModeHeader = 2'd0;
  localparam logic [ModeW-1:0] ModePayload = 2'd1;
  localparam logic [ModeW-1:0] ModeNested = 2'd2;
  localparam logic [ModeW-1:0] ModeHeaderSub = 2'd3;

  // Descriptor masks
  localparam logic [15:0] HdrLenMask   = 16'h007f;
  localparam logic [15:0] HdrIdMask    = 16'h7f80;
  localparam logic [15:0] LongLenMask  = 16'h07ff;
  localparam logic [15:0] LongIdMask   = 16'h7800;
  localparam logic [15:0] ShortLenMask = 16'h00ff;
  localparam logic [15:0] ShortIdMask  = 16'h7f00;
  localparam logic [15:0] LongFlagMask = 16'h8000;

  // Parser phase
  typedef enum logic [2:0] {
    PH_DESC_LO = 3'd0,
    PH_DESC_HI = 3'd1,
    PH_SKIP    = 3'd2,
    PH_SUBID   = 3'd3,
    PH_PENDING = 3'd4,
    PH_DONE    = 3'd5
  } phase_e;

endpackage

// ===== src/ie_ls_if.sv =====
// Valid/ready channel interfaces for the information-element list search.
// Depends on ie_ls_pkg for field widths.
interface ie_ls_in_if
  import ie_ls_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface ie_ls_out_if
  import ie_ls_pkg::*;
();
  logic            valid;
  logic            ready;
  logic            found;
  logic [PosW-1:0] content_offset;
  logic [LenW-1:0] content_length;

  modport source (output valid, output found, output content_offset,
                  output content_length, input ready);
  modport sink   (input valid, input found, input content_offset,
                  input content_length, output ready);
endinterface

// ===== src/ie_list_search_top.sv =====
// Results are registered: a result shows in the output register in the cycle after the byte that decides it is taken.
// Throughput: one byte per cycle; a byte is taken whenever the output register is
// empty or being emptied in the same cycle.
// Reset (rst_ni, asynchronous, active low): config and control registers to zero,
// parser awaits a descriptor low byte at list position zero, output register empty.
module ie_list_search_top
  import ie_ls_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  ie_ls_in_if.sink            in_if,
  ie_ls_out_if.source         out_if
);

  // Configuration registers
  logic [ModeW-1:0] mode_q;
  logic [ByteW-1:0] target_id_q;
  logic             target_long_q;
  logic [ByteW-1:0] target_sub_id_q;

  // Parser state
  phase_e           phase_q, phase_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [ByteW-1:0] desc_lo_q;
  logic [LenW-1:0]  skip_q, skip_d;
  logic [PosW-1:0]  pend_off_q, pend_off_d;
  logic [LenW-1:0]  pend_len_q, pend_len_d;

  // Output register
  logic            out_valid_q;
  logic            out_found_q;
  logic [PosW-1:0] out_off_q;
  logic [LenW-1:0] out_len_q;

  logic            in_acc;
  logic            emit;
  logic            res_found;
  logic [PosW-1:0] res_off;
  logic [LenW-1:0] res_len;

  // Descriptor decode
  logic [15:0]     desc;
  logic [LenW-1:0] d_len;
  logic            d_hit;
  logic [PosW-1:0] start;

  assign in_if.ready = !out_valid_q || out_if.ready;
  assign in_acc      = in_if.valid && in_if.ready;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q          <= ModeHeader;
      target_id_q     <= '0;
      target_long_q   <= 1'b0;
      target_sub_id_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegMode:        mode_q          <= cfg_data_i[ModeW-1:0];
        RegTargetId:    target_id_q     <= cfg_data_i;
        RegTargetLong:  target_long_q   <= cfg_data_i[0];
        RegTargetSubId: target_sub_id_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Split the descriptor by the selected layout and compare the ID
  assign desc  = {in_if.data_byte, desc_lo_q};
  assign start = pos_q + PosW'(1);

  always_comb begin
    d_len = '0;
    d_hit = 1'b0;
    unique case (mode_q)
      ModePayload: begin
        d_len = LenW'(desc & LongLenMask);
        d_hit = 4'((desc & LongIdMask) >> 11) == target_id_q[3:0];
      end
      ModeNested: begin
        if ((desc & LongFlagMask) != 16'h0) begin
          d_len = LenW'(desc & LongLenMask);
          d_hit = (4'((desc & LongIdMask) >> 11) == target_id_q[3:0]) && target_long_q;
        end else begin
          d_len = LenW'(desc & ShortLenMask);
          d_hit = (7'((desc & ShortIdMask) >> 8) == target_id_q[6:0]) && !target_long_q;
        end
      end
      default: begin
        d_len = LenW'(desc & HdrLenMask);
        d_hit = 8'((desc & HdrIdMask) >> 7) == target_id_q;
      end
    endcase
  end

  // Next state and result for the byte on the input
  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q + PosW'(1);
    skip_d     = skip_q;
    pend_off_d = pend_off_q;
    pend_len_d = pend_len_q;
    emit       = 1'b0;
    res_found  = 1'b0;
    res_off    = '0;
    res_len    = '0;

    unique case (phase_q)
      PH_DESC_LO: phase_d = PH_DESC_HI;
      PH_DESC_HI: begin
        if (mode_q == ModeHeaderSub) begin
          if (d_hit && d_len != '0) begin
            pend_off_d = start + PosW'(1);
            pend_len_d = d_len - LenW'(1);
            phase_d    = PH_SUBID;
          end else begin
            skip_d  = d_len;
            phase_d = (d_len != '0) ? PH_SKIP : PH_DESC_LO;
          end
        end else if (d_hit && mode_q == ModeNested && d_len != '0) begin
          pend_off_d = start;
          pend_len_d = d_len;
          skip_d     = d_len;
          phase_d    = PH_PENDING;
        end else if (d_hit) begin
          emit      = 1'b1;
          res_found = 1'b1;
          res_off   = start;
          res_len   = d_len;
          phase_d   = PH_DONE;
        end else begin
          skip_d  = d_len;
          phase_d = (d_len != '0) ? PH_SKIP : PH_DESC_LO;
        end
      end
      PH_SKIP: begin
        skip_d = skip_q - LenW'(1);
        if (skip_d == '0) phase_d = PH_DESC_LO;
      end
      PH_SUBID: begin
        if (in_if.data_byte == target_sub_id_q) begin
          emit      = 1'b1;
          res_found = 1'b1;
          res_off   = pend_off_q;
          res_len   = pend_len_q;
          phase_d   = PH_DONE;
        end else begin
          skip_d  = pend_len_q;
          phase_d = (pend_len_q != '0) ? PH_SKIP : PH_DESC_LO;
        end
      end
      PH_PENDING: begin
        skip_d = skip_q - LenW'(1);
        if (skip_d == '0) begin
          emit      = 1'b1;
          res_found = 1'b1;
          res_off   = pend_off_q;
          res_len   = pend_len_q;
          phase_d   = PH_DONE;
        end
      end
      default: ;
    endcase

    // End of list: report not found unless a match was already given
    if (in_if.last) begin
      if (!emit && phase_q != PH_DONE) begin
        emit = 1'b1;
      end
      phase_d = PH_DESC_LO;
      pos_d   = '0;
      skip_d  = '0;
    end
  end

  // State update on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_DESC_LO;
      pos_q      <= '0;
      skip_q     <= '0;
      pend_off_q <= '0;
      pend_len_q <= '0;
    end else if (in_acc) begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      skip_q     <= skip_d;
      pend_off_q <= pend_off_d;
      pend_len_q <= pend_len_d;
    end
  end

  // Descriptor low byte holds payload only
  always_ff @(posedge clk_i) begin
    if (in_acc && phase_q == PH_DESC_LO) desc_lo_q <= in_if.data_byte;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      out_found_q <= res_found;
      out_off_q   <= res_off;
      out_len_q   <= res_len;
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.found          = out_found_q;
  assign out_if.content_offset = out_off_q;
  assign out_if.content_length = out_len_q;

  // Checks
  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_if.last |=> phase_q == PH_DESC_LO && pos_q == '0 && skip_q == '0)
    else $error("list end did not restart the parser");

  a_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_SKIP || phase_q == PH_PENDING |-> skip_q != '0)
    else $error("skip phase with zero count");

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_if.last && phase_q != PH_DONE |=> out_valid_q)
    else $error("list ended without a result");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_found_q |-> out_off_q == '0 && out_len_q == '0)
    else $error("not-found item carries offset or length");

  a_done_no_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && phase_q == PH_DONE |-> !emit)
    else $error("second result for one list");

endmodule

// ===== test/tb_ie_list_search_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for ie_list_search_top: directed table, then random IE lists.
// Depends on ie_ls_pkg, the channel interfaces in ie_ls_if.sv and the top level.
module tb_ie_list_search_top;
  import ie_ls_pkg::*;

  // One search result, as it leaves the block
  typedef struct packed {
    logic            found;
    logic [PosW-1:0] off;
    logic [LenW-1:0] len;
  } search_res_t;

  // Directed table row: a register set or one byte, optionally with a typed-in result
  typedef enum logic {ROW_BYTE, ROW_REGS} row_kind_e;
  typedef struct packed {
    row_kind_e        kind;
    logic [ByteW-1:0] b;
    logic             lst;
    logic             typed;
    search_res_t      res;
    logic [ModeW-1:0] mode;
    logic [7:0]       tid;
    logic             lng;
    logic [7:0]       sub;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  ie_ls_in_if  in_ch ();
  ie_ls_out_if out_ch ();

  ie_list_search_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  always #10 clk_i = ~clk_i;

  // Register copies and parser state of the predictor
  logic [ModeW-1:0] reg_mode = ModeHeader;
  logic [7:0]       reg_tid  = '0;
  logic             reg_long = 1'b0;
  logic [7:0]       reg_sub  = '0;
  phase_e           ps_phase = PH_DESC_LO;
  logic [PosW-1:0]  ps_pos   = '0;
  logic [7:0]       ps_desc_lo = '0;
  logic [LenW-1:0]  ps_skip  = '0;
  logic [PosW-1:0]  ps_off   = '0;
  logic [LenW-1:0]  ps_len   = '0;

  search_res_t search_q[$];   // results still owed by the block
  logic [7:0]  list_q[$];     // bytes of the list being sent
  dir_row_t    dir_tab[$];
  int          mism_cnt = 0;
  int          live_items = 0;  // items taken while a search was still open
  logic        tag_typed = 1'b0;
  search_res_t tag_res = '0;
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  bit          hold_req = 1'b0;

  function automatic void skip_from(logic [LenW-1:0] n);
    ps_skip  = n;
    ps_phase = (n != 0) ? PH_SKIP : PH_DESC_LO;
  endfunction

  // Predictor: one byte in, at most one result out
  function automatic bit search_step(input logic [7:0] b, input logic lst,
                                     output search_res_t r);
    logic [15:0]     d;
    logic [PosW-1:0] start;
    logic [LenW-1:0] len;
    logic [7:0]      id;
    logic            id_hit;
    logic            lng;
    bit              emitted;
    r = '0;
    emitted = 1'b0;
    case (ps_phase)
      PH_DESC_LO: begin
        ps_desc_lo = b;
        ps_phase   = PH_DESC_HI;
      end
      PH_DESC_HI: begin
        d     = {b, ps_desc_lo};
        start = ps_pos + 16'd1;
        lng   = (d & LongFlagMask) != 0;
        if (reg_mode == ModePayload || (reg_mode == ModeNested && lng)) begin
          len    = LenW'(d & LongLenMask);
          id     = 8'((d & LongIdMask) >> 11);
          id_hit = id == (reg_tid & 8'h0f);
        end else if (reg_mode == ModeNested) begin
          len    = LenW'(d & ShortLenMask);
          id     = 8'((d & ShortIdMask) >> 8);
          id_hit = id == (reg_tid & 8'h7f);
        end else begin
          len    = LenW'(d & HdrLenMask);
          id     = 8'((d & HdrIdMask) >> 7);
          id_hit = id == reg_tid;
        end
        if (reg_mode == ModeNested) id_hit = id_hit && (lng == reg_long);
        if (reg_mode == ModeHeaderSub) begin
          if (id_hit && len != 0) begin
            ps_off   = start + 16'd1;
            ps_len   = len - 11'd1;
            ps_phase = PH_SUBID;
          end else begin
            skip_from(len);
          end
        end else if (id_hit && reg_mode == ModeNested && len != 0) begin
          // nested element must fit before it counts
          ps_off   = start;
          ps_len   = len;
          ps_skip  = len;
          ps_phase = PH_PENDING;
        end else if (id_hit) begin
          r        = {1'b1, start, len};
          emitted  = 1'b1;
          ps_phase = PH_DONE;
        end else begin
          skip_from(len);
        end
      end
      PH_SKIP: begin
        ps_skip = ps_skip - 11'd1;
        if (ps_skip == 0) ps_phase = PH_DESC_LO;
      end
      PH_SUBID: begin
        if (b == reg_sub) begin
          r        = {1'b1, ps_off, ps_len};
          emitted  = 1'b1;
          ps_phase = PH_DONE;
        end else begin
          skip_from(ps_len);
        end
      end
      PH_PENDING: begin
        ps_skip = ps_skip - 11'd1;
        if (ps_skip == 0) begin
          r        = {1'b1, ps_off, ps_len};
          emitted  = 1'b1;
          ps_phase = PH_DONE;
        end
      end
      default: ;
    endcase
    ps_pos = ps_pos + 16'd1;
    // end of list: not found unless already decided
    if (lst) begin
      if (!emitted && ps_phase != PH_DONE) begin
        r       = '0;
        emitted = 1'b1;
      end
      ps_phase = PH_DESC_LO;
      ps_pos   = '0;
      ps_skip  = '0;
    end
    return emitted;
  endfunction

  function automatic void log_mismatch(string what, search_res_t w, search_res_t g);
    mism_cnt++;
    if (mism_cnt <= 10)
      $display("%0t: %s: expected found=%0d off=%0d len=%0d, got found=%0d off=%0d len=%0d",
               $realtime, what, w.found, w.off, w.len, g.found, g.off, g.len);
  endfunction

  // Scoreboard: compare results, then predict for the item taken at this edge
  always @(posedge clk_i) begin : scoreboard
    search_res_t got_r;
    search_res_t want_r;
    bit          emit;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        got_r = {out_ch.found, out_ch.content_offset, out_ch.content_length};
        if (search_q.size() == 0) begin
          log_mismatch("unexpected result", '0, got_r);
        end else begin
          want_r = search_q.pop_front();
          if (got_r !== want_r) log_mismatch("result mismatch", want_r, got_r);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (ps_phase != PH_DONE) live_items++;
        emit = search_step(in_ch.data_byte, in_ch.last, want_r);
        if (tag_typed) begin
          want_r = tag_res;
          emit   = 1'b1;
        end
        if (emit) search_q.push_back(want_r);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegMode:        reg_mode = cfg_data_i[ModeW-1:0];
          RegTargetId:    reg_tid  = cfg_data_i;
          RegTargetLong:  reg_long = cfg_data_i[0];
          RegTargetSubId: reg_sub  = cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Receiver: random hold-offs per result, plus one long stall on request
  initial begin : receiver
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (300) @(negedge clk_i);
      end
      if ($urandom_range(0, 19) == 0) rx_idle = !rx_idle;
      gap = rx_idle ? $urandom_range(0, 13) : 0;
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // Offer one byte at the falling edge and hold it until taken
  task automatic send_item(logic [7:0] b, logic l, logic typed, search_res_t res);
    int gap;
    gap = tx_idle ? $urandom_range(0, 13) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last      <= l;
    tag_typed       <= typed;
    tag_res         <= res;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk_i);
  endtask

  task automatic send_list();
    foreach (list_q[i]) send_item(list_q[i], i == list_q.size() - 1, 1'b0, '0);
  endtask

  // Pause the sender until every owed result is out and the block has settled
  task automatic wait_results_out();
    in_ch.valid <= 1'b0;
    while (search_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_regs(logic [ModeW-1:0] m, logic [7:0] id, logic l, logic [7:0] s);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= RegMode;
    cfg_data_i <= CfgDataW'(m);
    @(negedge clk_i);
    cfg_idx_i  <= RegTargetId;
    cfg_data_i <= id;
    @(negedge clk_i);
    cfg_idx_i  <= RegTargetLong;
    cfg_data_i <= CfgDataW'(l);
    @(negedge clk_i);
    cfg_idx_i  <= RegTargetSubId;
    cfg_data_i <= s;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic logic [15:0] pack_desc(logic [ModeW-1:0] m, logic lng, logic [7:0] id,
                                            logic [LenW-1:0] len);
    case (m)
      ModePayload: return {lng, id[3:0], len};
      ModeNested:  return lng ? {1'b1, id[3:0], len} : {1'b0, id[6:0], len[7:0]};
      default:     return {lng, id, len[6:0]};
    endcase
  endfunction

  function automatic logic [7:0] pick_ext8();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // Random list: mostly well-formed elements, some truncated, some noise
  task automatic build_list();
    int              n_el;
    int              max_len;
    int              pick;
    int              keep;
    logic            lng;
    logic [7:0]      id;
    logic [LenW-1:0] len;
    logic [15:0]     d;
    list_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 10)) list_q.push_back(8'($urandom));
      return;
    end
    n_el = $urandom_range(1, 5);
    repeat (n_el) begin
      if (reg_mode == ModeNested)
        lng = ($urandom_range(0, 3) != 0) ? reg_long : !reg_long;
      else
        lng = 1'($urandom);
      id = ($urandom_range(0, 2) == 0) ? reg_tid : 8'($urandom);
      if (reg_mode == ModePayload || (reg_mode == ModeNested && lng)) max_len = 2047;
      else if (reg_mode == ModeNested) max_len = 255;
      else max_len = 127;
      pick = $urandom_range(0, 199);
      if (pick < 170) len = LenW'($urandom_range(0, 5));
      else if (pick < 198) len = LenW'($urandom_range(6, 40));
      else len = LenW'($urandom_range(0, max_len));
      d = pack_desc(reg_mode, lng, id, len);
      list_q.push_back(d[7:0]);
      list_q.push_back(d[15:8]);
      for (int k = 0; k < len; k++) begin
        if (k == 0 && reg_mode == ModeHeaderSub && $urandom_range(0, 1) == 1)
          list_q.push_back(reg_sub);
        else
          list_q.push_back(8'($urandom));
      end
    end
    // broken list: ends early, possibly inside an element or a descriptor
    if ($urandom_range(0, 6) == 0) begin
      keep = $urandom_range(1, list_q.size());
      while (list_q.size() > keep) void'(list_q.pop_back());
    end
  endtask

  initial begin : main
    int          lists_left;
    bit          pressure_done;
    logic [15:0] d;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = RegMode;
    cfg_data_i      = '0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last      = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table; typed results only where obvious
    // after reset: zero descriptor matches ID 0, length 0
    dir_tab.push_back({ROW_BYTE, 8'h00, 1'b0, 1'b0, 28'h0, ModeHeader, 8'h00, 1'b0, 8'h00});
    dir_tab.push_back({ROW_BYTE, 8'h00, 1'b1, 1'b1, {1'b1, 16'd2, 11'd0},
                       ModeHeader, 8'h00, 1'b0, 8'h00});
    // descriptor cut short
    dir_tab.push_back({ROW_BYTE, 8'hff, 1'b1, 1'b1, 28'h0, ModeHeader, 8'h00, 1'b0, 8'h00});
    // header extremes: match before the content, list ends at once
    dir_tab.push_back({ROW_REGS, 8'h00, 1'b0, 1'b0, 28'h0, ModeHeader, 8'hff, 1'b1, 8'h00});
    dir_tab.push_back({ROW_BYTE, 8'hff, 1'b0, 1'b0, 28'h0, ModeHeader, 8'h00, 1'b0, 8'h00});
    dir_tab.push_back({ROW_BYTE, 8'hff, 1'b1, 1'b1, {1'b1, 16'd2, 11'd127},
                       ModeHeader, 8'h00, 1'b0, 8'h00});
    // payload extremes, then a byte after the match that is ignored
    dir_tab.push_back({ROW_REGS, 8'h00, 1'b0, 1'b0, 28'h0, ModePayload, 8'hff, 1'b0, 8'h00});
    dir_tab.push_back({ROW_BYTE, 8'hff, 1'b0, 1'b0, 28'h0, ModeHeader, 8'h00, 1'b0, 8'h00});
    dir_tab.push_back({ROW_BYTE, 8'hff, 1'b0, 1'b1, {1'b1, 16'd2, 11'd2047},
                       ModeHeader, 8'h00, 1'b0, 8'h00});
    dir_tab.push_back({ROW_BYTE, 8'h00, 1'b1, 1'b0, 28'h0, ModeHeader, 8'h00, 1'b0, 8'h00});
    // short nested element ID 5, length 2, that fits
    dir_tab.push_back({ROW_REGS, 8'h00, 1'b0, 1'b0, 28'h0, ModeNested, 8'h05, 1'b0, 8'h00});
    dir_tab.push_back({ROW_BYTE, 8'h02, 1'b0, 1'b0, 28'h0, ModeHeader, 8'h00, 1'b0, 8'h00});
    dir_tab.push_back({ROW_BYTE, 8'h05, 1'b0, 1'b0, 28'h0, ModeHeader, 8'h00, 1'b0, 8'h00});
    dir_tab.push_back({ROW_BYTE, 8'haa, 1'b0, 1'b0, 28'h0, ModeHeader, 8'h00, 1'b0, 8'h00});
    dir_tab.push_back({ROW_BYTE, 8'h55, 1'b1, 1'b1, {1'b1, 16'd2, 11'd2},
                       ModeHeader, 8'h00, 1'b0, 8'h00});
    // nested element that does not fit: list ends inside it
    dir_tab.push_back({ROW_BYTE, 8'h03, 1'b0, 1'b0, 28'h0, ModeHeader, 8'h00, 1'b0, 8'h00});
    dir_tab.push_back({ROW_BYTE, 8'h05, 1'b0, 1'b0, 28'h0, ModeHeader, 8'h00, 1'b0, 8'h00});
    dir_tab.push_back({ROW_BYTE, 8'h11, 1'b1, 1'b1, 28'h0, ModeHeader, 8'h00, 1'b0, 8'h00});
    // sub-ID mode: first element has the wrong sub-ID and is skipped
    dir_tab.push_back({ROW_REGS, 8'h00, 1'b0, 1'b0, 28'h0, ModeHeaderSub, 8'h12, 1'b0, 8'h7e});
    dir_tab.push_back({ROW_BYTE, 8'h03, 1'b0, 1'b0, 28'h0, ModeHeader, 8'h00, 1'b0, 8'h00});
    dir_tab.push_back({ROW_BYTE, 8'h09, 1'b0, 1'b0, 28'h0, ModeHeader, 8'h00, 1'b0, 8'h00});
    dir_tab.push_back({ROW_BYTE, 8'h7d, 1'b0, 1'b0, 28'h0, ModeHeader, 8'h00, 1'b0, 8'h00});
    dir_tab.push_back({ROW_BYTE, 8'h00, 1'b0, 1'b0, 28'h0, ModeHeader, 8'h00, 1'b0, 8'h00});
    dir_tab.push_back({ROW_BYTE, 8'h00, 1'b0, 1'b0, 28'h0, ModeHeader, 8'h00, 1'b0, 8'h00});
    dir_tab.push_back({ROW_BYTE, 8'h03, 1'b0, 1'b0, 28'h0, ModeHeader, 8'h00, 1'b0, 8'h00});
    dir_tab.push_back({ROW_BYTE, 8'h09, 1'b0, 1'b0, 28'h0, ModeHeader, 8'h00, 1'b0, 8'h00});
    // registers rewritten while a match waits for its sub-ID byte
    dir_tab.push_back({ROW_REGS, 8'h00, 1'b0, 1'b0, 28'h0, ModeHeader, 8'h12, 1'b0, 8'h7d});
    dir_tab.push_back({ROW_BYTE, 8'h7d, 1'b1, 1'b0, 28'h0, ModeHeader, 8'h00, 1'b0, 8'h00});

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_REGS) begin
        wait_results_out();
        set_regs(dir_tab[i].mode, dir_tab[i].tid, dir_tab[i].lng, dir_tab[i].sub);
      end else begin
        send_item(dir_tab[i].b, dir_tab[i].lst, dir_tab[i].typed, dir_tab[i].res);
      end
    end

    // Random lists, with register changes between batches
    lists_left    = 0;
    pressure_done = 1'b0;
    while (live_items < 1300) begin
      if (!pressure_done && live_items > 400) begin
        // fill the block: receiver stalls while matching lists keep coming
        wait_results_out();
        set_regs(ModeHeader, 8'h21, 1'b0, 8'h00);
        tx_idle  = 1'b0;
        hold_req = 1'b1;
        d = pack_desc(ModeHeader, 1'b0, 8'h21, 11'd1);
        repeat (20) begin
          list_q = '{d[7:0], d[15:8], 8'($urandom)};
          send_list();
        end
        wait_results_out();
        pressure_done = 1'b1;
        lists_left    = 0;
      end
      if (lists_left == 0) begin
        wait_results_out();
        set_regs(ModeW'($urandom_range(0, 3)), pick_ext8(), 1'($urandom), pick_ext8());
        lists_left = $urandom_range(3, 8);
      end
      if ($urandom_range(0, 5) == 0) tx_idle = !tx_idle;
      build_list();
      send_list();
      lists_left--;
    end

    // Drain and report
    in_ch.valid <= 1'b0;
    while (search_q.size() != 0) @(negedge clk_i);
    repeat (5) @(negedge clk_i);
    if (mism_cnt == 0 && search_q.size() == 0)
      $display("tb_ie_list_search_top passed");
    else
      $display("tb_ie_list_search_top failed");
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #(20_000_000);
    $display("tb_ie_list_search_top failed");
    $finish;
  end

endmodule
